FILE: rtl/stbs_pkg.sv
// package for the sorted table binary search unit
// shared widths, request codes, default parameters and the control state type
// no dependencies
package stbs_pkg;

	// fixed field widths of the ports
	localparam int CFG_W     = 11;
	localparam int IN_IDX_W  = 10;
	localparam int FIELD_W   = 32;
	localparam int POS_W     = 10;

	// parameter defaults
	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_WIDTH = 32;

	// request codes carried by req_type
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// search sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/stbs_ram.sv
// table memory for the sorted table binary search unit
// one write port, one read port, read data registered
// depends on nothing
module stbs_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/sorted_table_binary_search_unit.sv
// top level of the sorted table binary search unit
// holds the search sequencer and output register, instantiates stbs_ram
// depends on stbs_pkg and stbs_ram
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   in       | in_valid / in_stall    | req_type, entry_index, entry_value, search_key
//   out      | out_valid / out_stall  | found, position
//   cfg      | cfg_valid / cfg_ready  | cfg_data (table_size)
//
// a write item is taken in idle; a search item runs p probes,
// p <= ceil(log2(table_size+1)), so at most 11 probes for 1024 entries
// each probe is one registered read of the table memory and one compare
// in_stall is held high while a search runs; the result waits in an output
// register, so a new item is taken while the previous result is stalled
// reset clears control and table_size; table contents are undefined until written
module sorted_table_binary_search_unit #(
	parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic        [stbs_pkg::IN_IDX_W-1:0]  entry_index,
	input  logic signed [stbs_pkg::FIELD_W-1:0]   entry_value,
	input  logic signed [stbs_pkg::FIELD_W-1:0]   search_key,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	output logic        [stbs_pkg::POS_W-1:0]     position,
	// configuration channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [stbs_pkg::CFG_W-1:0]     cfg_data
);

	import stbs_pkg::*;

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW0 = $clog2(TABLE_DEPTH + 1);
	localparam int NW  = (NW0 > CFG_W) ? NW0 : CFG_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0]              table_size_q;
	logic [NW-1:0]                 lo_q, hi_q;
	logic [NW-1:0]                 lo_d, hi_d;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic                          res_found_q;
	logic [POS_W-1:0]              res_pos_q;
	logic                          out_valid_q;
	logic                          found_q;
	logic [POS_W-1:0]              position_q;

	logic                          in_acc;
	logic                          acc_write;
	logic                          acc_search;
	logic                          slot_free;
	logic [NW-1:0]                 n_eff;
	logic [NW-1:0]                 mid;
	logic                          wr_en;
	logic                          rd_en;
	logic [VALUE_WIDTH-1:0]        rd_data;
	logic signed [VALUE_WIDTH-1:0] entry_s;
	logic                          hit;
	logic                          less;

	// handshake decode
	assign in_acc     = in_valid && !in_stall;
	assign acc_write  = in_acc && (req_type == REQ_WRITE);
	assign acc_search = in_acc && (req_type == REQ_SEARCH);
	assign slot_free  = !out_valid_q || !out_stall;
	assign cfg_ready  = 1'b1;

	// entries in use, clipped to the depth
	assign n_eff = (NW'(table_size_q) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
		: NW'(table_size_q);

	// probe position, lo + (hi - 1 - lo) / 2 over the half-open range
	assign mid = lo_q + ((hi_q - lo_q - NW'(1)) >> 1);

	// compare of the entry read back against the key
	assign entry_s = $signed(rd_data);
	assign hit     = (entry_s == key_q);
	assign less    = (entry_s < key_q);

	// range update after a compare
	always_comb begin
		lo_d = lo_q;
		hi_d = hi_q;
		if (less) begin
			lo_d = mid + NW'(1);
		end else begin
			hi_d = mid;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_search) begin
					state_d = (n_eff == '0) ? ST_DONE : ST_PROBE;
				end
			end
			ST_PROBE: state_d = ST_CMP;
			ST_CMP: begin
				if (hit || !(lo_d < hi_d)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state dependent outputs
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				wr_en    = acc_write && (NW'(entry_index) < NW'(TABLE_DEPTH));
			end
			ST_PROBE: rd_en = 1'b1;
			ST_CMP:   rd_en = 1'b0;
			ST_DONE:  rd_en = 1'b0;
			default:  in_stall = 1'b1;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			table_size_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				table_size_q <= cfg_data;
			end
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_search) begin
					key_q       <= VALUE_WIDTH'(search_key);
					lo_q        <= '0;
					hi_q        <= n_eff;
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
				end
			end
			ST_CMP: begin
				lo_q <= lo_d;
				hi_q <= hi_d;
				if (hit) begin
					res_found_q <= 1'b1;
					res_pos_q   <= mid[POS_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

	// table memory
	stbs_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (VALUE_WIDTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(entry_index)),
		.wr_data (VALUE_WIDTH'(entry_value)),
		.rd_en   (rd_en),
		.rd_addr (mid[AW-1:0]),
		.rd_data (rd_data)
	);

endmodule

FILE: rtl/stbs_checker.sv
// port level checks for the sorted table binary search unit
// holds the checker module and its bind to the top level
// depends on stbs_pkg
module stbs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          req_type,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          found,
	input logic [stbs_pkg::POS_W-1:0]    position
);

	import stbs_pkg::*;

	// a stalled result item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(found) && $stable(position)))
		else $error("stalled result item changed");

	// a miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (position == '0))
		else $error("miss with non-zero position");

	// a search item blocks the input while it runs
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && req_type == REQ_SEARCH) |=> in_stall)
		else $error("input taken during a search");

	// a write item never produces a result
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && req_type == REQ_WRITE) |=> !$rose(out_valid))
		else $error("result item after a write item");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.found     (found),
	.position  (position)
);
